### src/pse_pkg.sv
// Shared types and constants for the postfix stack evaluator.
// No dependencies; every other file of the block refers to it by scoped names.
package pse_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    localparam int TQ_DEPTH = 4;
    localparam int TQ_PTR_W = $clog2(TQ_DEPTH);
    localparam int TQ_CNT_W = $clog2(TQ_DEPTH + 1);

    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_POW  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_DIVZ  = 2'd3;

    typedef enum logic [1:0] {
        KIND_PUSH,
        KIND_BINARY,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  op;
        logic [63:0] value;
        logic        last;
    } token_t;

    typedef struct packed {
        logic        go;
        logic [63:0] x;
        logic [63:0] y;
    } arith_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } mul_rsp_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [63:0] rem;
    } div_rsp_t;

endpackage

### src/pse_front.sv
// Front part: accepts items, classifies the opcode and queues tokens.
// Depends on pse_pkg.
module pse_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [2:0]           opcode,
    input  logic signed [63:0]   operand_value,
    input  logic                 last_token,
    output logic                 tok_empty,
    output pse_pkg::token_t      tok,
    input  logic                 tok_pop
);

    pse_pkg::token_t                 q_mem [pse_pkg::TQ_DEPTH];
    logic [pse_pkg::TQ_PTR_W-1:0]    wr_ptr_reg;
    logic [pse_pkg::TQ_PTR_W-1:0]    rd_ptr_reg;
    logic [pse_pkg::TQ_CNT_W-1:0]    cnt_reg;
    pse_pkg::token_t                 in_tok;
    logic                            do_wr;
    logic                            do_rd;

    always_comb
    begin
        in_tok.op    = opcode;
        in_tok.value = operand_value;
        in_tok.last  = last_token;
        case (opcode)
            pse_pkg::OP_PUSH: in_tok.kind = pse_pkg::KIND_PUSH;
            pse_pkg::OP_ADD,
            pse_pkg::OP_SUB,
            pse_pkg::OP_MUL,
            pse_pkg::OP_DIV,
            pse_pkg::OP_POW:  in_tok.kind = pse_pkg::KIND_BINARY;
            default:          in_tok.kind = pse_pkg::KIND_NOP;
        endcase
    end

    assign full      = (cnt_reg == pse_pkg::TQ_CNT_W'(pse_pkg::TQ_DEPTH));
    assign tok_empty = (cnt_reg == '0);
    assign tok       = q_mem[rd_ptr_reg];
    assign do_wr     = push && !full;
    assign do_rd     = tok_pop && !tok_empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_mem[wr_ptr_reg] <= in_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### src/pse_mul.sv
// Iterative 64x64 multiplier, low 64 bits, one 32x32 product per cycle.
// Depends on pse_pkg.
module pse_mul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pse_pkg::arith_req_t  req,
    output pse_pkg::mul_rsp_t    rsp
);

    logic [63:0] x_reg;
    logic [63:0] y_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] prod_full;

    // Phase 0: lo*lo, phase 1: lo*hi, phase 2: hi*lo; cross terms land shifted by 32.
    always_comb
    begin
        case (step_reg)
            2'd0:    begin mx = x_reg[31:0];  my = y_reg[31:0];  end
            2'd1:    begin mx = x_reg[31:0];  my = y_reg[63:32]; end
            default: begin mx = x_reg[63:32]; my = y_reg[31:0];  end
        endcase
    end

    // Full 64-bit product of two 32-bit halves.
    assign prod_full = mx * my;

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            x_reg <= req.x;
            y_reg <= req.y;
        end
        if (busy_reg)
        begin
            prod_reg <= prod_full;
            case (step_reg)
                2'd0:    acc_reg <= acc_reg;
                2'd1:    acc_reg <= prod_reg;
                default: acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = acc_reg;

endmodule

### src/pse_div.sv
// Restoring unsigned 64-bit divider, one quotient bit per cycle.
// Depends on pse_pkg.
module pse_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pse_pkg::arith_req_t  req,
    output pse_pkg::div_rsp_t    rsp
);

    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        done_reg;
    logic [64:0] shifted;
    logic [64:0] diff;

    assign shifted = {rem_reg, quo_reg[63]};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            rem_reg <= '0;
            quo_reg <= req.x;
            den_reg <= req.y;
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[64])
            begin
                rem_reg <= diff[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                cnt_reg <= 7'd64;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 7'd1)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

### src/pse_back.sv
// Back part: operand stack memory, token sequencer and result register.
// Depends on pse_pkg; drives the multiplier and the divider.
module pse_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tok_empty,
    input  pse_pkg::token_t      tok,
    output logic                 tok_pop,
    output pse_pkg::arith_req_t  mul_req,
    input  pse_pkg::mul_rsp_t    mul_rsp,
    output pse_pkg::arith_req_t  div_req,
    input  pse_pkg::div_rsp_t    div_rsp,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [31:0]   result_value,
    output logic [1:0]           status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD_B,
        S_RD_A,
        S_OP,
        S_WAIT_MUL,
        S_WAIT_DIV,
        S_POW_LOOP,
        S_POW_ACC,
        S_POW_SQ,
        S_WRITE,
        S_FINISH,
        S_EMIT
    } state_t;

    logic [63:0]                 stack_mem [pse_pkg::STACK_DEPTH];
    logic [63:0]                 rdata_reg;
    state_t                      state_reg;
    pse_pkg::token_t             tok_reg;
    logic [pse_pkg::SP_W-1:0]    sp_reg;
    logic [1:0]                  err_reg;
    logic [63:0]                 a_reg;
    logic [63:0]                 b_reg;
    logic [63:0]                 r_reg;
    logic [63:0]                 acc_reg;
    logic [63:0]                 base_reg;
    logic [63:0]                 exp_reg;
    logic                        out_valid_reg;
    logic [31:0]                 out_value_reg;
    logic [1:0]                  out_status_reg;
    pse_pkg::arith_req_t         mul_req_reg;
    pse_pkg::arith_req_t         div_req_reg;

    logic [pse_pkg::SP_W-1:0]    sp_m1;
    logic [pse_pkg::SP_W-1:0]    sp_m2;
    logic                        mem_we;
    logic [pse_pkg::ADDR_W-1:0]  waddr;
    logic [pse_pkg::ADDR_W-1:0]  raddr;
    logic [63:0]                 wdata;
    logic                        sp_full;
    logic [63:0]                 mag_a;
    logic [63:0]                 mag_b;
    logic [63:0]                 floor_q;
    logic [63:0]                 neg_pow;

    assign sp_m1   = sp_reg - pse_pkg::SP_W'(1);
    assign sp_m2   = sp_reg - pse_pkg::SP_W'(2);
    assign sp_full = (sp_reg == pse_pkg::SP_W'(pse_pkg::STACK_DEPTH));

    assign tok_pop = (state_reg == S_IDLE) && !tok_empty && (!tok.last || !out_valid_reg);

    assign mag_a = a_reg[63] ? (64'd0 - a_reg) : a_reg;
    assign mag_b = b_reg[63] ? (64'd0 - b_reg) : b_reg;

    always_comb
    begin
        if (a_reg[63] ^ b_reg[63])
        begin
            floor_q = (64'd0 - div_rsp.quo) - {63'd0, (div_rsp.rem != 64'd0)};
        end
        else
        begin
            floor_q = div_rsp.quo;
        end
    end

    // Negative exponent: one stays one, minus one alternates by parity, else zero.
    always_comb
    begin
        if (a_reg == 64'd1)
        begin
            neg_pow = 64'd1;
        end
        else if (a_reg == '1)
        begin
            neg_pow = b_reg[0] ? '1 : 64'd1;
        end
        else
        begin
            neg_pow = 64'd0;
        end
    end

    always_comb
    begin
        mem_we = 1'b0;
        waddr  = sp_reg[pse_pkg::ADDR_W-1:0];
        wdata  = tok_reg.value;
        raddr  = sp_m1[pse_pkg::ADDR_W-1:0];
        case (state_reg)
            S_EXEC:
            begin
                mem_we = (tok_reg.kind == pse_pkg::KIND_PUSH) && !sp_full;
            end
            S_RD_B:
            begin
                raddr = sp_m2[pse_pkg::ADDR_W-1:0];
            end
            S_WRITE:
            begin
                mem_we = 1'b1;
                waddr  = sp_m2[pse_pkg::ADDR_W-1:0];
                wdata  = r_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[waddr] <= wdata;
        end
        rdata_reg <= stack_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sp_reg         <= '0;
            err_reg        <= pse_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            mul_req_reg.go <= 1'b0;
            div_req_reg.go <= 1'b0;
        end
        else
        begin
            mul_req_reg.go <= 1'b0;
            div_req_reg.go <= 1'b0;
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (tok_pop)
                    begin
                        tok_reg   <= tok;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    // The read of the top entry goes out here.
                    case (tok_reg.kind)
                        pse_pkg::KIND_PUSH:
                        begin
                            if (sp_full)
                            begin
                                if (err_reg == pse_pkg::ST_OK)
                                begin
                                    err_reg <= pse_pkg::ST_OVER;
                                end
                            end
                            else
                            begin
                                sp_reg <= sp_reg + pse_pkg::SP_W'(1);
                            end
                            state_reg <= S_FINISH;
                        end
                        pse_pkg::KIND_BINARY:
                        begin
                            if (sp_reg < pse_pkg::SP_W'(2))
                            begin
                                if (err_reg == pse_pkg::ST_OK)
                                begin
                                    err_reg <= pse_pkg::ST_UNDER;
                                end
                                state_reg <= S_FINISH;
                            end
                            else
                            begin
                                state_reg <= S_RD_B;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_FINISH;
                        end
                    endcase
                end
                S_RD_B:
                begin
                    b_reg     <= rdata_reg;
                    state_reg <= S_RD_A;
                end
                S_RD_A:
                begin
                    a_reg     <= rdata_reg;
                    state_reg <= S_OP;
                end
                S_OP:
                begin
                    case (tok_reg.op)
                        pse_pkg::OP_ADD:
                        begin
                            r_reg     <= a_reg + b_reg;
                            state_reg <= S_WRITE;
                        end
                        pse_pkg::OP_SUB:
                        begin
                            r_reg     <= a_reg - b_reg;
                            state_reg <= S_WRITE;
                        end
                        pse_pkg::OP_MUL:
                        begin
                            mul_req_reg.go <= 1'b1;
                            mul_req_reg.x  <= a_reg;
                            mul_req_reg.y  <= b_reg;
                            state_reg      <= S_WAIT_MUL;
                        end
                        pse_pkg::OP_DIV:
                        begin
                            if (b_reg == 64'd0)
                            begin
                                if (err_reg == pse_pkg::ST_OK)
                                begin
                                    err_reg <= pse_pkg::ST_DIVZ;
                                end
                                r_reg     <= 64'd0;
                                state_reg <= S_WRITE;
                            end
                            else
                            begin
                                div_req_reg.go <= 1'b1;
                                div_req_reg.x  <= mag_a;
                                div_req_reg.y  <= mag_b;
                                state_reg      <= S_WAIT_DIV;
                            end
                        end
                        default:
                        begin
                            if (b_reg[63])
                            begin
                                if (a_reg == 64'd0 && err_reg == pse_pkg::ST_OK)
                                begin
                                    err_reg <= pse_pkg::ST_DIVZ;
                                end
                                r_reg     <= neg_pow;
                                state_reg <= S_WRITE;
                            end
                            else
                            begin
                                acc_reg   <= 64'd1;
                                base_reg  <= a_reg;
                                exp_reg   <= b_reg;
                                state_reg <= S_POW_LOOP;
                            end
                        end
                    endcase
                end
                S_WAIT_MUL:
                begin
                    if (mul_rsp.done)
                    begin
                        r_reg     <= mul_rsp.res;
                        state_reg <= S_WRITE;
                    end
                end
                S_WAIT_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        r_reg     <= floor_q;
                        state_reg <= S_WRITE;
                    end
                end
                S_POW_LOOP:
                begin
                    // Multiply into the accumulator on a set bit, then square the base; stop at a zero exponent.
                    if (exp_reg == 64'd0)
                    begin
                        r_reg     <= acc_reg;
                        state_reg <= S_WRITE;
                    end
                    else if (exp_reg[0])
                    begin
                        mul_req_reg.go <= 1'b1;
                        mul_req_reg.x  <= acc_reg;
                        mul_req_reg.y  <= base_reg;
                        state_reg      <= S_POW_ACC;
                    end
                    else
                    begin
                        mul_req_reg.go <= 1'b1;
                        mul_req_reg.x  <= base_reg;
                        mul_req_reg.y  <= base_reg;
                        state_reg      <= S_POW_SQ;
                    end
                end
                S_POW_ACC:
                begin
                    if (mul_rsp.done)
                    begin
                        acc_reg        <= mul_rsp.res;
                        mul_req_reg.go <= 1'b1;
                        mul_req_reg.x  <= base_reg;
                        mul_req_reg.y  <= base_reg;
                        state_reg      <= S_POW_SQ;
                    end
                end
                S_POW_SQ:
                begin
                    if (mul_rsp.done)
                    begin
                        base_reg  <= mul_rsp.res;
                        exp_reg   <= {1'b0, exp_reg[63:1]};
                        state_reg <= S_POW_LOOP;
                    end
                end
                S_WRITE:
                begin
                    sp_reg    <= sp_m1;
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    // The read of the top entry goes out here.
                    state_reg <= tok_reg.last ? S_EMIT : S_IDLE;
                end
                S_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    if (sp_reg == '0)
                    begin
                        out_value_reg  <= 32'd0;
                        out_status_reg <= (err_reg == pse_pkg::ST_OK) ? pse_pkg::ST_UNDER
                                                                      : err_reg;
                    end
                    else
                    begin
                        out_value_reg  <= rdata_reg[31:0];
                        out_status_reg <= err_reg;
                    end
                    sp_reg    <= '0;
                    err_reg   <= pse_pkg::ST_OK;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign mul_req      = mul_req_reg;
    assign div_req      = div_req_reg;
    assign empty        = !out_valid_reg;
    assign result_value = out_value_reg;
    assign status       = out_status_reg;

endmodule

### src/postfix_stack_evaluator.sv
// Postfix stack evaluator: front token queue, back sequencer with 64-bit stack.
// Multiply and divide wait on their units; a zero divisor or a negative exponent is
// settled without them, and power runs one multiply per clear and two per set exponent
// bit; the last token also takes the result into the result register.
// Throughput is one token at a time in the back. Reset (rst_n, asynchronous, active low)
// clears stack pointer, status and queues; stack contents are undefined until pushed.
module postfix_stack_evaluator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [2:0]           opcode,
    input  logic signed [63:0]   operand_value,
    input  logic                 last_token,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [31:0]   result_value,
    output logic [1:0]           status
);

    // Token queue between the front and the back.
    logic                 tok_empty;
    pse_pkg::token_t      tok;
    logic                 tok_pop;

    // Arithmetic units, driven by the back sequencer; the multiplier serves multiply and power.
    pse_pkg::arith_req_t  mul_req;
    pse_pkg::mul_rsp_t    mul_rsp;
    pse_pkg::arith_req_t  div_req;
    pse_pkg::div_rsp_t    div_rsp;

    // Accept items and classify them; hold up to four tokens.
    pse_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .operand_value (operand_value),
        .last_token    (last_token),
        .tok_empty     (tok_empty),
        .tok           (tok),
        .tok_pop       (tok_pop)
    );

    // Low 64 bits of a product.
    pse_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // Unsigned quotient and remainder of magnitudes.
    pse_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Carry out tokens on the stack; the result register decouples the pop side.
    pse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_empty    (tok_empty),
        .tok          (tok),
        .tok_pop      (tok_pop),
        .mul_req      (mul_req),
        .mul_rsp      (mul_rsp),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .empty        (empty),
        .pop          (pop),
        .result_value (result_value),
        .status       (status)
    );

endmodule

### dv/tb_top.sv
// Testbench for the postfix stack evaluator: directed and random token streams.
// Depends on src/pse_pkg.sv and src/postfix_stack_evaluator.sv.
`timescale 1ns / 1ps

module tb_top;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [2:0]         opcode;
    logic signed [63:0] operand_value;
    logic               last_token;
    logic               empty;
    logic               pop;
    logic signed [31:0] result_value;
    logic [1:0]         status;

    // Expected result of one expression: low word and status.
    typedef struct {
        logic [31:0] value;
        logic [1:0]  code;
    } answer_t;

    answer_t     answer_q[$];
    logic [63:0] eval_stack[pse_pkg::STACK_DEPTH];
    int          eval_sp;
    logic [1:0]  eval_status;
    int          fail_count = 0;
    int          items_sent;
    int          answers_seen = 0;
    int          idle_cycles = 0;
    int          burst_left;
    bit          pop_steady;

    localparam int WATCHDOG_LIMIT = 20000;

    postfix_stack_evaluator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .operand_value (operand_value),
        .last_token    (last_token),
        .empty         (empty),
        .pop           (pop),
        .result_value  (result_value),
        .status        (status)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Keep the first error of the expression.
    function automatic void raise_status(logic [1:0] code);
        if (eval_status == pse_pkg::ST_OK)
            eval_status = code;
    endfunction

    // Floor quotient: truncate on magnitudes, then step down when signs differ
    // and something is left over.
    function automatic logic [63:0] floor_quotient(logic [63:0] a, logic [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        logic [63:0] r;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q  = ma / mb;
        r  = ma % mb;
        if (a[63] ^ b[63])
        begin
            q = -q;
            if (r != 0)
                q = q - 1;
        end
        return q;
    endfunction

    // Exact power modulo 2^64, with the negative exponent rules.
    function automatic logic [63:0] wrap_power(logic [63:0] a, logic [63:0] b);
        logic [63:0] acc;
        logic [63:0] base;
        logic [63:0] e;
        acc  = 64'd1;
        base = a;
        e    = b;
        if (b[63])
        begin
            if (a == 64'd1)
                return 64'd1;
            if (a == '1)
                return b[0] ? '1 : 64'd1;
            if (a == 64'd0)
                raise_status(pse_pkg::ST_DIVZ);
            return 64'd0;
        end
        while (e != 0)
        begin
            if (e[0])
                acc = acc * base;
            base = base * base;
            e    = e >> 1;
        end
        return acc;
    endfunction

    // Advance the predicted stack by one token; queue an answer on the last one.
    function automatic void evaluate_token(logic [2:0] op, logic [63:0] val, logic last);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        answer_t     ans;
        if (op == pse_pkg::OP_PUSH)
        begin
            if (eval_sp >= pse_pkg::STACK_DEPTH)
                raise_status(pse_pkg::ST_OVER);
            else
            begin
                eval_stack[eval_sp] = val;
                eval_sp++;
            end
        end
        else if (op <= pse_pkg::OP_POW)
        begin
            if (eval_sp < 2)
                raise_status(pse_pkg::ST_UNDER);
            else
            begin
                b = eval_stack[eval_sp - 1];
                a = eval_stack[eval_sp - 2];
                r = 64'd0;
                case (op)
                    pse_pkg::OP_ADD: r = a + b;
                    pse_pkg::OP_SUB: r = a - b;
                    pse_pkg::OP_MUL: r = a * b;
                    pse_pkg::OP_DIV:
                    begin
                        if (b == 0)
                            raise_status(pse_pkg::ST_DIVZ);
                        else
                            r = floor_quotient(a, b);
                    end
                    default: r = wrap_power(a, b);
                endcase
                eval_sp--;
                eval_stack[eval_sp - 1] = r;
            end
        end
        if (last)
        begin
            if (eval_sp == 0)
            begin
                raise_status(pse_pkg::ST_UNDER);
                ans.value = 32'd0;
            end
            else
                ans.value = eval_stack[eval_sp - 1][31:0];
            ans.code = eval_status;
            answer_q.push_back(ans);
            eval_sp     = 0;
            eval_status = pse_pkg::ST_OK;
        end
    endfunction

    // Send one item: hold push until accepted, with random bursts and gaps.
    task automatic send_token(logic [2:0] op, logic [63:0] val, logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push          <= 1'b1;
        opcode        <= op;
        operand_value <= val;
        last_token    <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        evaluate_token(op, val, last);
        items_sent++;
    endtask

    task automatic finish_sending();
        push <= 1'b0;
        @(posedge clk);
    endtask

    // Pause until every predicted answer has been popped.
    task automatic wait_drained();
        finish_sending();
        while (answer_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] random_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: w = 64'($urandom_range(0, 9));
            1: w = -64'($urandom_range(1, 9));
            2: w = {1'b1, 63'd0};
            3: w = {1'b0, {63{1'b1}}};
            default: ;
        endcase
        return w;
    endfunction

    task automatic test_extremes();
        send_token(pse_pkg::OP_PUSH, {1'b0, {63{1'b1}}}, 1'b1);
        send_token(pse_pkg::OP_PUSH, {1'b1, 63'd0}, 1'b1);
        send_token(pse_pkg::OP_PUSH, '1, 1'b0);
        send_token(pse_pkg::OP_PUSH, 64'd1, 1'b0);
        send_token(pse_pkg::OP_ADD, 64'd0, 1'b1);
    endtask

    task automatic test_every_operation();
        logic [2:0] op;
        for (int k = pse_pkg::OP_ADD; k <= pse_pkg::OP_POW; k++)
        begin
            op = k[2:0];
            send_token(pse_pkg::OP_PUSH, -64'sd7, 1'b0);
            send_token(pse_pkg::OP_PUSH, 64'd3, 1'b0);
            send_token(op, 64'd0, 1'b1);
        end
    endtask

    task automatic test_special_cases();
        // Divide by zero, and the sticky status after a later underflow.
        send_token(pse_pkg::OP_PUSH, 64'd5, 1'b0);
        send_token(pse_pkg::OP_PUSH, 64'd0, 1'b0);
        send_token(pse_pkg::OP_DIV, 64'd0, 1'b0);
        send_token(pse_pkg::OP_ADD, 64'd0, 1'b1);
        // Most negative over minus one wraps.
        send_token(pse_pkg::OP_PUSH, {1'b1, 63'd0}, 1'b0);
        send_token(pse_pkg::OP_PUSH, '1, 1'b0);
        send_token(pse_pkg::OP_DIV, 64'd0, 1'b1);
        // Negative exponents on 0, 1, -1 and 2.
        send_token(pse_pkg::OP_PUSH, 64'd0, 1'b0);
        send_token(pse_pkg::OP_PUSH, '1, 1'b0);
        send_token(pse_pkg::OP_POW, 64'd0, 1'b1);
        send_token(pse_pkg::OP_PUSH, '1, 1'b0);
        send_token(pse_pkg::OP_PUSH, -64'sd3, 1'b0);
        send_token(pse_pkg::OP_POW, 64'd0, 1'b1);
        send_token(pse_pkg::OP_PUSH, 64'd1, 1'b0);
        send_token(pse_pkg::OP_PUSH, -64'sd4, 1'b0);
        send_token(pse_pkg::OP_POW, 64'd0, 1'b0);
        send_token(pse_pkg::OP_PUSH, 64'd2, 1'b0);
        send_token(pse_pkg::OP_PUSH, -64'sd1, 1'b0);
        send_token(pse_pkg::OP_POW, 64'd0, 1'b1);
        // Unused opcodes, then the last token on an empty stack.
        send_token(3'd6, 64'd9, 1'b0);
        send_token(3'd7, 64'd9, 1'b1);
    endtask

    task automatic test_overflow();
        for (int k = 0; k <= pse_pkg::STACK_DEPTH; k++)
            send_token(pse_pkg::OP_PUSH, random_word(), 1'b0);
        send_token(pse_pkg::OP_MUL, 64'd0, 1'b1);
    endtask

    // Mostly well-formed expressions with random content, some noise.
    task automatic test_random_expressions(int target);
        int          depth;
        int          ops;
        logic [2:0]  op;
        logic [63:0] v;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                // Noise: any opcode, random last.
                op = 3'($urandom_range(0, 7));
                send_token(op, random_word(), $urandom_range(0, 3) == 0);
            end
            else
            begin
                ops = $urandom_range(0, 5);
                send_token(pse_pkg::OP_PUSH, random_word(), 1'b0);
                depth = 1;
                for (int k = 0; k < ops; k++)
                begin
                    send_token(pse_pkg::OP_PUSH, random_word(), 1'b0);
                    depth++;
                    if ($urandom_range(0, 2) == 0 && depth < pse_pkg::STACK_DEPTH)
                    begin
                        send_token(pse_pkg::OP_PUSH, random_word(), 1'b0);
                        depth++;
                    end
                    op = 3'($urandom_range(pse_pkg::OP_ADD, pse_pkg::OP_POW));
                    v  = random_word();
                    if (op == pse_pkg::OP_POW && $urandom_range(0, 1))
                    begin
                        // Keep most exponents small to bound the run.
                        send_token(pse_pkg::OP_POW, {58'd0, v[5:0]}, 1'b0);
                    end
                    else
                        send_token(op, v, 1'b0);
                    depth--;
                end
                op = $urandom_range(0, 1) ? pse_pkg::OP_ADD : pse_pkg::OP_PUSH;
                send_token(op, random_word(), 1'b1);
            end
        end
    endtask

    // Result checker: pop on a pattern of its own; compare against the oldest answer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop        <= 1'b0;
            pop_steady <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (answer_q.size() == 0)
                begin
                    $display("%0t: unexpected result value %h status %0d",
                             $time, result_value, status);
                    fail_count++;
                end
                else
                begin
                    if (result_value !== answer_q[0].value)
                    begin
                        $display("%0t: result_value expected %h actual %h",
                                 $time, answer_q[0].value, result_value);
                        fail_count++;
                    end
                    if (status !== answer_q[0].code)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, answer_q[0].code, status);
                        fail_count++;
                    end
                    void'(answer_q.pop_front());
                end
                answers_seen++;
            end
            if ($urandom_range(0, 63) == 0)
                pop_steady <= ~pop_steady;
            pop <= pop_steady ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    // Watchdog: count cycles in which nothing moves.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && (answer_q.size() != 0 || push))
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        opcode        = pse_pkg::OP_PUSH;
        operand_value = '0;
        last_token    = 1'b0;
        eval_sp       = 0;
        eval_status   = pse_pkg::ST_OK;
        items_sent    = 0;
        burst_left    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_every_operation();
        test_special_cases();
        wait_drained();
        test_overflow();
        test_random_expressions(700);
        wait_drained();
        // Let any trailing no-result token work its way out.
        repeat (200) @(posedge clk);

        $display("covered %0d tokens and %0d results: pushes, all operators,",
                 items_sent, answers_seen);
        $display("stack overflow and underflow, divide by zero and power corners");
        if (fail_count == 0 && answer_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### postfix_stack_evaluator.f
src/pse_pkg.sv
src/pse_front.sv
src/pse_mul.sv
src/pse_div.sv
src/pse_back.sv
src/postfix_stack_evaluator.sv
dv/tb_top.sv
